// File: rtl/pts_pkg.sv
// Shared types and codes for the priority task scheduler.
// No dependencies; imported by the top level and the testbench.
package pts_pkg;

	localparam int TASK_W = 6;
	localparam int PRIO_W = 15;
	localparam int TS_W   = 32;
	localparam int RT_W   = 32;

	localparam logic [1:0] CMD_RESCHED     = 2'd0;
	localparam logic [1:0] CMD_DEFER_START = 2'd1;
	localparam logic [1:0] CMD_DEFER_STOP  = 2'd2;
	localparam logic [1:0] CMD_MAKE_READY  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DEFERRED = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] task_priority;
		logic              current_eligible;
		logic [TS_W-1:0]   timestamp;
	} sched_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              switched;
		logic [TASK_W-1:0] old_task;
		logic [TASK_W-1:0] new_task;
		logic [RT_W-1:0]   old_runtime;
	} sched_rsp_t;

	typedef struct packed {
		logic [TASK_W-1:0] id;
		logic [PRIO_W-1:0] prio;
	} qentry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_RESCH,
		S_INS_RD,
		S_INS_CMP,
		S_DONE
	} state_t;

endpackage

// File: rtl/pts_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/priority_task_scheduler_with_defer_top.sv
// Top level of the priority task scheduler: sequencer, ready queue and runtime table.
// Depends on pts_pkg and pts_ram.
//
// One command word is taken when start is high and busy is low; one result word
// follows on rsp, marked by done for a single cycle, and must be taken then. Defer
// starts, rejected commands, deferred reschedules and defer stops that owe no
// reschedule go from S_DECIDE to S_DONE; a reschedule that keeps or dispatches a
// task, or finds nothing to run, also passes through S_RESCH on the way. Make-ready
// and a preempting reschedule run a sorted insert into the ready queue RAM, which
// walks back from the tail over every queued entry of lower priority, one RAM read
// and one compare and move per entry. busy drops the cycle after done.
module priority_task_scheduler_with_defer_top #(
	parameter int NUM_TASKS = 64,
	parameter int MAX_DEFER = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pts_pkg::sched_req_t req,
	output logic               done,
	output pts_pkg::sched_rsp_t rsp
);

	import pts_pkg::*;

	localparam int QAW      = $clog2(NUM_TASKS);
	localparam int CW       = $clog2(NUM_TASKS + 1);
	localparam int RT_DEPTH = (NUM_TASKS < 64) ? NUM_TASKS : 64;
	localparam int RTAW     = $clog2(RT_DEPTH);
	localparam int DW       = $clog2(MAX_DEFER + 1);
	localparam int QE_W     = TASK_W + PRIO_W;

	state_t state_q, state_d;

	sched_req_t        req_q;
	logic [TASK_W-1:0] old_q;
	logic [TASK_W-1:0] cur_q;
	logic [PRIO_W-1:0] cur_prio_q;
	logic [TS_W-1:0]   ss_q;
	logic [DW-1:0]     depth_q;
	logic              pend_q;
	logic [CW-1:0]     count_q;
	logic [QAW-1:0]    head_q;
	logic [QAW-1:0]    j_q;
	logic [TASK_W-1:0] ins_id_q;
	logic [PRIO_W-1:0] ins_prio_q;
	qentry_t           hd_q;
	logic [RT_W-1:0]   rt_q;
	logic [RT_W-1:0]   delta_q;
	logic [1:0]        status_q;
	logic              sw_q;
	logic [RT_DEPTH-1:0] rt_vld_q;

	logic              q_we;
	logic [QAW-1:0]    q_waddr;
	qentry_t           q_wdata;
	logic [QAW-1:0]    q_raddr;
	logic [QE_W-1:0]   q_rdata_raw;
	qentry_t           q_rdata;
	logic              rt_we;
	logic [RT_W-1:0]   rt_wdata;
	logic [RT_W-1:0]   rt_rdata;
	logic [RTAW-1:0]   cur_idx;
	logic [RT_W-1:0]   rt_sum;
	logic [QAW-1:0]    head_nxt;
	logic              accept;
	logic              keep_cur;

	function automatic logic [QAW-1:0] qidx(input logic [QAW-1:0] base,
		input logic [QAW-1:0] off);
		logic [QAW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (QAW+1)'(NUM_TASKS)) begin
			s = s - (QAW+1)'(NUM_TASKS);
		end
		return s[QAW-1:0];
	endfunction

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE);
	assign cur_idx  = cur_q[RTAW-1:0];
	assign rt_sum   = rt_q + delta_q;
	assign head_nxt = (head_q == QAW'(NUM_TASKS - 1)) ? '0 : head_q + 1'b1;
	assign q_rdata  = qentry_t'(q_rdata_raw);
	assign keep_cur = (count_q == '0) || (cur_prio_q > hd_q.prio);

	assign rsp.status      = status_q;
	assign rsp.switched    = sw_q;
	assign rsp.old_task    = old_q;
	assign rsp.new_task    = cur_q;
	assign rsp.old_runtime = rt_q;

	pts_ram #(.WIDTH(QE_W), .DEPTH(NUM_TASKS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata_raw)
	);

	pts_ram #(.WIDTH(RT_W), .DEPTH(RT_DEPTH)) u_runtime_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (cur_idx),
		.wdata (rt_wdata),
		.raddr (cur_idx),
		.rdata (rt_rdata)
	);

	// queue and runtime RAM port control and next state
	always_comb begin
		state_d  = state_q;
		q_we     = 1'b0;
		q_waddr  = qidx(head_q, j_q);
		q_wdata  = '{id: ins_id_q, prio: ins_prio_q};
		q_raddr  = head_q;
		rt_we    = 1'b0;
		rt_wdata = rt_sum;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				case (req_q.command)
					CMD_RESCHED: begin
						if (depth_q == '0) begin
							state_d = S_RESCH;
						end
					end
					CMD_DEFER_STOP: begin
						if (depth_q == DW'(1) && pend_q) begin
							state_d = S_RESCH;
						end
					end
					CMD_MAKE_READY: begin
						if (count_q != CW'(NUM_TASKS)
							&& 32'(req_q.task_id) < 32'(NUM_TASKS)) begin
							state_d = S_INS_RD;
						end
					end
					default: begin
					end
				endcase
			end
			S_RESCH: begin
				state_d = S_DONE;
				if (req_q.current_eligible) begin
					rt_we = 1'b1;
					if (!keep_cur) begin
						state_d = S_INS_RD;
					end
				end
			end
			S_INS_RD: begin
				q_raddr = qidx(head_q, j_q - 1'b1);
				if (j_q == '0) begin
					q_we    = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				q_we = 1'b1;
				if (q_rdata.prio < ins_prio_q) begin
					q_wdata = q_rdata;
					state_d = S_INS_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			cur_prio_q <= '0;
			ss_q       <= '0;
			depth_q    <= '0;
			pend_q     <= 1'b0;
			count_q    <= '0;
			head_q     <= '0;
			rt_vld_q   <= '0;
		end else begin
			case (state_q)
				S_DECIDE: begin
					case (req_q.command)
						CMD_RESCHED: begin
							if (depth_q != '0) begin
								pend_q <= 1'b1;
							end
						end
						CMD_DEFER_START: begin
							if (depth_q != DW'(MAX_DEFER)) begin
								if (depth_q == '0) begin
									pend_q <= 1'b0;
								end
								depth_q <= depth_q + 1'b1;
							end
						end
						CMD_DEFER_STOP: begin
							if (depth_q != '0) begin
								depth_q <= depth_q - 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_RESCH: begin
					if (req_q.current_eligible) begin
						rt_vld_q[cur_idx] <= 1'b1;
					end
					if (req_q.current_eligible && keep_cur) begin
						ss_q <= req_q.timestamp;
					end else if (count_q != '0) begin
						head_q     <= head_nxt;
						count_q    <= count_q - 1'b1;
						cur_q      <= hd_q.id;
						cur_prio_q <= hd_q.prio;
						ss_q       <= req_q.timestamp;
					end
				end
				S_INS_RD: begin
					if (j_q == '0) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_INS_CMP: begin
					if (!(q_rdata.prio < ins_prio_q)) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result word status and switch flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			sw_q     <= 1'b0;
		end else begin
			case (state_q)
				S_DECIDE: begin
					sw_q     <= 1'b0;
					status_q <= ST_OK;
					case (req_q.command)
						CMD_RESCHED: begin
							if (depth_q != '0) begin
								status_q <= ST_DEFERRED;
							end
						end
						CMD_DEFER_START: begin
							if (depth_q == DW'(MAX_DEFER)) begin
								status_q <= ST_ERROR;
							end
						end
						CMD_DEFER_STOP: begin
							if (depth_q == '0) begin
								status_q <= ST_ERROR;
							end
						end
						default: begin
							if (count_q == CW'(NUM_TASKS)
								|| 32'(req_q.task_id) >= 32'(NUM_TASKS)) begin
								status_q <= ST_ERROR;
							end
						end
					endcase
				end
				S_RESCH: begin
					if (req_q.current_eligible && keep_cur) begin
						sw_q <= 1'b0;
					end else if (count_q != '0) begin
						sw_q <= 1'b1;
					end else begin
						status_q <= ST_ERROR;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			old_q <= cur_q;
		end
		case (state_q)
			S_DECIDE: begin
				rt_q       <= rt_vld_q[cur_idx] ? rt_rdata : '0;
				hd_q       <= q_rdata;
				delta_q    <= req_q.timestamp - ss_q;
				ins_id_q   <= req_q.task_id;
				ins_prio_q <= req_q.task_priority;
				j_q        <= count_q[QAW-1:0];
			end
			S_RESCH: begin
				if (req_q.current_eligible) begin
					rt_q <= rt_sum;
				end
				ins_id_q   <= cur_q;
				ins_prio_q <= cur_prio_q;
				j_q        <= QAW'(count_q - 1'b1);
			end
			S_INS_CMP: begin
				if (q_rdata.prio < ins_prio_q) begin
					j_q <= j_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_TASKS))
		else $error("ready count beyond queue depth");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.switched |-> rsp.status == ST_OK)
		else $error("switch reported with non-ok status");

	a_no_switch_same: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.switched |-> rsp.new_task == rsp.old_task)
		else $error("task changed without switch");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("no busy after accept");

endmodule

// File: verif/priority_task_scheduler_with_defer_top_tb.sv
// Self-checking testbench for priority_task_scheduler_with_defer_top: directed and random
// command words, with a cycle-free scheduler predictor checking every result word.
// Depends on pts_pkg and the scheduler RTL.
module priority_task_scheduler_with_defer_top_tb;
	import pts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TASKS = 64;
	localparam int MAX_DEFER = 255;
	localparam int WORD_TOTAL = 1200;
	localparam int PHASE_A_END = 400;
	localparam int PHASE_B_END = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sched_req_t req = '0;
	logic done;
	sched_rsp_t rsp;

	priority_task_scheduler_with_defer_top #(
		.NUM_TASKS(NUM_TASKS),
		.MAX_DEFER(MAX_DEFER)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// scheduler state as predicted
	qentry_t ready_q[$];
	logic [TASK_W-1:0] cur_task = '0;
	logic [PRIO_W-1:0] cur_prio = '0;
	logic [TS_W-1:0] slice_t0 = '0;
	logic [RT_W-1:0] run_total [NUM_TASKS] = '{default: '0};
	int unsigned defer_lvl = 0;
	logic resched_owed = 1'b0;

	sched_req_t cmd_backlog[$];
	sched_rsp_t due_outcomes[$];
	sched_rsp_t want;
	int taken = 0;
	int fault_count = 0;
	logic [TS_W-1:0] clock_ms = '0;

	function automatic void enqueue_task(input logic [TASK_W-1:0] id,
			input logic [PRIO_W-1:0] prio);
		int pos = 0;
		while (pos < ready_q.size() && ready_q[pos].prio >= prio)
			pos++;
		ready_q.insert(pos, {id, prio});
	endfunction

	function automatic logic [1:0] resched_now(input logic elig, input logic [TS_W-1:0] ts,
			inout logic sw);
		qentry_t head;
		if (defer_lvl != 0) begin
			resched_owed = 1'b1;
			return ST_DEFERRED;
		end
		if (elig) begin
			run_total[cur_task] = run_total[cur_task] + (ts - slice_t0);
			if (ready_q.size() == 0 || cur_prio > ready_q[0].prio) begin
				slice_t0 = ts;
				return ST_OK;
			end
			head = ready_q.pop_front();
			enqueue_task(cur_task, cur_prio);
		end else begin
			if (ready_q.size() == 0)
				return ST_ERROR;
			head = ready_q.pop_front();
		end
		cur_task = head.id;
		cur_prio = head.prio;
		slice_t0 = ts;
		sw = 1'b1;
		return ST_OK;
	endfunction

	function automatic sched_rsp_t schedule_step(input sched_req_t w);
		sched_rsp_t r;
		logic sw;
		logic [TASK_W-1:0] was;
		sw = 1'b0;
		was = cur_task;
		r.status = ST_OK;
		case (w.command)
			CMD_RESCHED: begin
				r.status = resched_now(w.current_eligible, w.timestamp, sw);
			end
			CMD_DEFER_START: begin
				if (defer_lvl >= MAX_DEFER)
					r.status = ST_ERROR;
				else begin
					if (defer_lvl == 0)
						resched_owed = 1'b0;
					defer_lvl++;
				end
			end
			CMD_DEFER_STOP: begin
				if (defer_lvl == 0)
					r.status = ST_ERROR;
				else begin
					defer_lvl--;
					if (defer_lvl == 0 && resched_owed)
						r.status = resched_now(w.current_eligible, w.timestamp, sw);
				end
			end
			default: begin
				if (ready_q.size() >= NUM_TASKS || int'(w.task_id) >= NUM_TASKS)
					r.status = ST_ERROR;
				else
					enqueue_task(w.task_id, w.task_priority);
			end
		endcase
		r.switched = sw;
		r.old_task = was;
		r.new_task = cur_task;
		r.old_runtime = run_total[was];
		return r;
	endfunction

	function automatic void push_word(input logic [1:0] c, input logic [TASK_W-1:0] id,
			input logic [PRIO_W-1:0] p, input logic e, input logic [TS_W-1:0] ts);
		sched_req_t w;
		w.command = c;
		w.task_id = id;
		w.task_priority = p;
		w.current_eligible = e;
		w.timestamp = ts;
		cmd_backlog.push_back(w);
	endfunction

	// half the time one of eight crowded levels (0 to 7), so equal-priority ordering gets exercised
	function automatic logic [PRIO_W-1:0] rand_prio();
		if ($urandom_range(1))
			return PRIO_W'($urandom_range(7));
		return PRIO_W'($urandom);
	endfunction

	function automatic logic [TS_W-1:0] next_ts();
		if ($urandom_range(9) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(50);
		return clock_ms;
	endfunction

	function automatic void push_resched();
		push_word(CMD_RESCHED, TASK_W'($urandom), rand_prio(), 1'($urandom_range(1)),
			next_ts());
	endfunction

	function automatic void push_ready();
		push_word(CMD_MAKE_READY, TASK_W'($urandom), rand_prio(), 1'($urandom_range(1)),
			next_ts());
	endfunction

	task automatic flag_fault(input string msg);
		fault_count++;
		if (fault_count <= 100)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			flag_fault($sformatf("%s got %0h want %0h", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				due_outcomes.push_back(schedule_step(req));
				taken++;
			end
			if (!start || !busy) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >=
						((taken < PHASE_A_END) ? 11 : (taken < PHASE_B_END) ? 50 : 0)) begin
					start <= 1'b1;
					req <= cmd_backlog.pop_front();
				end else
					start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_outcomes.size() == 0)
				flag_fault("result word with none outstanding");
			else begin
				want = due_outcomes.pop_front();
				check_field("status", rsp.status, want.status);
				check_field("switched", rsp.switched, want.switched);
				check_field("old_task", rsp.old_task, want.old_task);
				check_field("new_task", rsp.new_task, want.new_task);
				check_field("old_runtime", rsp.old_runtime, want.old_runtime);
			end
		end
	end

	initial begin
		int pick;
		int n;

		// ineligible with empty queue, then kept with empty queue at the top timestamp
		push_word(CMD_RESCHED, '0, '0, 1'b0, '0);
		push_word(CMD_RESCHED, '1, '1, 1'b1, '1);
		push_word(CMD_DEFER_STOP, '0, '0, 1'b0, '0);
		push_word(CMD_MAKE_READY, 6'd63, '1, 1'b0, '0);
		push_word(CMD_MAKE_READY, 6'd0, '0, 1'b1, '1);
		push_word(CMD_MAKE_READY, 6'd5, '1, 1'b0, 32'h5555_5555);
		// preempt with runtime wrap, then equal-priority preempt
		push_word(CMD_RESCHED, '0, '0, 1'b1, 32'd0);
		push_word(CMD_RESCHED, '0, '0, 1'b1, 32'd100);
		push_word(CMD_DEFER_START, '1, '1, 1'b1, 32'hAAAA_AAAA);
		push_word(CMD_RESCHED, '0, '0, 1'b1, 32'd200);
		push_word(CMD_DEFER_START, '0, '0, 1'b0, 32'd210);
		push_word(CMD_DEFER_STOP, '0, '0, 1'b1, 32'd220);
		push_word(CMD_DEFER_STOP, '0, '0, 1'b0, 32'd230);
		push_word(CMD_DEFER_START, '0, '0, 1'b0, 32'd240);
		push_word(CMD_DEFER_STOP, '0, '0, 1'b1, 32'd250);
		push_word(CMD_RESCHED, '0, '0, 1'b0, 32'd260);
		push_word(CMD_RESCHED, '0, '0, 1'b0, 32'd270);
		push_word(CMD_RESCHED, '0, '0, 1'b0, 32'd280);

		// queue filled past capacity
		repeat (NUM_TASKS + 2)
			push_ready();
		repeat (4)
			push_resched();

		// deferral nested to the limit and one past it, then unwound to zero and one stop beyond
		repeat (MAX_DEFER)
			push_word(CMD_DEFER_START, TASK_W'($urandom), rand_prio(),
				1'($urandom_range(1)), next_ts());
		push_resched();
		push_word(CMD_DEFER_START, '0, '0, 1'b1, next_ts());
		repeat (MAX_DEFER)
			push_word(CMD_DEFER_STOP, TASK_W'($urandom), rand_prio(),
				1'($urandom_range(1)), next_ts());
		push_word(CMD_DEFER_STOP, '0, '0, 1'b1, next_ts());

		while (cmd_backlog.size() < WORD_TOTAL) begin
			pick = $urandom_range(99);
			if (pick < 25)
				push_ready();
			else if (pick < 70)
				push_resched();
			else if (pick < 90) begin
				push_word(CMD_DEFER_START, TASK_W'($urandom), rand_prio(),
					1'($urandom_range(1)), next_ts());
				n = $urandom_range(4);
				repeat (n)
					if ($urandom_range(1))
						push_resched();
					else
						push_ready();
				if ($urandom_range(3) == 0) begin
					push_word(CMD_DEFER_START, '0, rand_prio(), 1'($urandom_range(1)),
						next_ts());
					push_resched();
					push_word(CMD_DEFER_STOP, '0, rand_prio(), 1'($urandom_range(1)),
						next_ts());
				end
				push_word(CMD_DEFER_STOP, TASK_W'($urandom), rand_prio(),
					1'($urandom_range(1)), next_ts());
			end else
				push_word(2'($urandom_range(3)), TASK_W'($urandom), PRIO_W'($urandom),
					1'($urandom_range(1)), $urandom);
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(posedge clk);
		while (due_outcomes.size() != 0)
			@(posedge clk);
		repeat (2 * NUM_TASKS + 8) @(posedge clk);
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/priority_task_scheduler_with_defer_top.sv
verif/priority_task_scheduler_with_defer_top_tb.sv
